FILE: hw/rtl/calendar_date_offset_and_distance_top_macros.svh
// assertion macros for the calendar date offset and distance block
`ifndef CALENDAR_DATE_OFFSET_AND_DISTANCE_TOP_MACROS_SVH
`define CALENDAR_DATE_OFFSET_AND_DISTANCE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication under active-low reset
`define CDOD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cdod assertion failed");
// next-cycle implication under active-low reset
`define CDOD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cdod assertion failed");
`else
`define CDOD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CDOD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/cdod_pkg.sv
// shared types, status codes and month tables for the date arithmetic block
`timescale 1ns / 1ps

package cdod_pkg;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_A_BAD = 2'd1;
    localparam logic [1:0] ST_B_BAD = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic check;
        logic y_init;
        logic walk1;
        logic eval1;
        logic eval2;
        logic walk2;
        logic mon_init;
        logic mon_step;
        logic out_load;
    } cdod_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic a_rng_bad;
        logic walk1_done;
        logic date_bad;
        logic oor;
        logic walk2_done;
        logic mon_done;
        logic out_free;
    } cdod_sts_t;

    // days in a month, zero for a month code that means nothing
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
        logic [4:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                  n = 5'd30;
            4'd2:                                     n = lp ? 5'd29 : 5'd28;
            default:                                  n = 5'd0;
        endcase
        return n;
    endfunction

    // days in the year before the first of a month
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic lp);
        logic [8:0] n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        if (lp && (m > 4'd2) && (m <= 4'd12)) begin
            n = n + 9'd1;
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/cdod_ctrl.sv
// controller state machine sequencing the date arithmetic datapath
`timescale 1ns / 1ps
`include "calendar_date_offset_and_distance_top_macros.svh"

module cdod_ctrl import cdod_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cdod_sts_t sts,
    output cdod_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_WALK1  = 3'd2;
    localparam logic [2:0] S_EVAL1  = 3'd3;
    localparam logic [2:0] S_EVAL2  = 3'd4;
    localparam logic [2:0] S_WALK2  = 3'd5;
    localparam logic [2:0] S_MONTH  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                cmd.y_init = 1'b1;
                state_next = sts.a_rng_bad ? S_FINISH : S_WALK1;
            end
            S_WALK1: begin
                cmd.walk1 = 1'b1;
                if (sts.walk1_done) begin
                    state_next = S_EVAL1;
                end
            end
            S_EVAL1: begin
                cmd.eval1  = 1'b1;
                state_next = S_EVAL2;
            end
            S_EVAL2: begin
                if (sts.date_bad) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.eval2  = 1'b1;
                    cmd.y_init = 1'b1;
                    state_next = S_WALK2;
                end
            end
            S_WALK2: begin
                if (sts.oor) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.walk2 = 1'b1;
                    if (sts.walk2_done) begin
                        cmd.mon_init = 1'b1;
                        state_next   = S_MONTH;
                    end
                end
            end
            S_MONTH: begin
                cmd.mon_step = 1'b1;
                if (sts.mon_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `CDOD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `CDOD_ASSERT_IMP(a_load_needs_slot, aclk, aresetn, cmd.out_load, sts.out_free && !s_ready)

endmodule

FILE: hw/rtl/cdod_dp.sv
// datapath: year walker, serial day arithmetic, month walker and result register
`timescale 1ns / 1ps
`include "calendar_date_offset_and_distance_top_macros.svh"

module cdod_dp import cdod_pkg::*; #(
    parameter int FIRST_YEAR = 1900,
    parameter int YEAR_SPAN  = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [4:0]         s_day_a,
    input  logic [3:0]         s_month_a,
    input  logic [11:0]        s_year_a,
    input  logic [4:0]         s_day_b,
    input  logic [3:0]         s_month_b,
    input  logic [11:0]        s_year_b,
    input  logic signed [18:0] s_day_offset,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_sum_day,
    output logic [3:0]         m_sum_month,
    output logic [11:0]        m_sum_year,
    output logic [2:0]         m_sum_weekday,
    output logic [17:0]        m_day_distance,
    output logic [1:0]         m_status,
    input  cdod_cmd_t          cmd,
    output cdod_sts_t          sts
);

    localparam int LAST_YEAR = FIRST_YEAR + YEAR_SPAN - 1;
    localparam int F0        = FIRST_YEAR - 1;
    localparam int LAST_DAY  = 365 * YEAR_SPAN + (LAST_YEAR / 4 - F0 / 4)
                             - (LAST_YEAR / 100 - F0 / 100) + (LAST_YEAR / 400 - F0 / 400);
    localparam int JAN1_WD   = (F0 + F0 / 4 - F0 / 100 + F0 / 400 + 1) % 7;
    localparam int YW        = $clog2(LAST_YEAR + 2);
    localparam int SW        = $clog2(LAST_DAY + 1);
    localparam int SSW       = $clog2(LAST_DAY + 262145) + 1;

    localparam logic signed [SSW-1:0] S_ONE  = SSW'(1);
    localparam logic signed [SSW-1:0] S_LAST = SSW'(LAST_DAY);

    // add two weekdays modulo 7
    function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= 4'd7) begin
            t = t - 4'd7;
        end
        return t[2:0];
    endfunction

    // narrow value modulo 7 by compare and subtract
    function automatic logic [2:0] mod7_6(input logic [5:0] x);
        logic [5:0] r;
        r = x;
        for (int i = 0; i < 6; i++) begin
            if (r >= 6'd7) begin
                r = r - 6'd7;
            end
        end
        return r[2:0];
    endfunction

    // latched item
    logic [4:0]         da_reg, db_reg;
    logic [3:0]         ma_reg, mb_reg;
    logic [11:0]        ya_reg, yb_reg;
    logic signed [18:0] off_reg;

    // flags
    logic a_bad_reg, b_bad_reg, oor_reg, a_cap_reg, b_cap_reg;

    // year walker
    logic [YW-1:0] y_reg;
    logic [1:0]    m4_reg;
    logic [6:0]    m100_reg;
    logic [8:0]    m400_reg;
    logic [SW-1:0] acc_reg;
    logic [2:0]    wd_reg;

    // serial values
    logic [SW-1:0] base_a_reg, base_b_reg;
    logic          leap_a_reg, leap_b_reg;
    logic [SW-1:0] sa_reg, sb_reg, dist_reg, rem_reg;
    logic [3:0]    m_reg;

    // result register
    logic        m_valid_reg;
    logic [4:0]  sum_day_reg;
    logic [3:0]  sum_month_reg;
    logic [11:0] sum_year_reg;
    logic [2:0]  sum_wd_reg;
    logic [17:0] dist_out_reg;
    logic [1:0]  status_reg;

    // range checks on the latched dates
    logic a_rng_ok, b_rng_ok;
    assign a_rng_ok = (32'(ya_reg) >= FIRST_YEAR) && (32'(ya_reg) <= LAST_YEAR)
                    && (ma_reg >= 4'd1) && (ma_reg <= 4'd12);
    assign b_rng_ok = (32'(yb_reg) >= FIRST_YEAR) && (32'(yb_reg) <= LAST_YEAR)
                    && (mb_reg >= 4'd1) && (mb_reg <= 4'd12);

    // leap year from the running remainders
    logic       leap;
    logic [8:0] ylen;
    assign leap = (m4_reg == 2'd0) && ((m100_reg != 7'd0) || (m400_reg == 9'd0));
    assign ylen = leap ? 9'd366 : 9'd365;

    // year walk completion
    logic y_eq_a, y_eq_b, walk1_done, walk2_done, adv;
    assign y_eq_a     = (32'(y_reg) == 32'(ya_reg));
    assign y_eq_b     = (32'(y_reg) == 32'(yb_reg));
    assign walk1_done = (y_eq_a || a_cap_reg) && (b_bad_reg || y_eq_b || b_cap_reg);
    assign walk2_done = (rem_reg <= SW'(ylen));
    assign adv        = (cmd.walk1 && !walk1_done) || (cmd.walk2 && !walk2_done);

    // month walk
    logic [4:0] mlen;
    logic       mon_done;
    assign mlen     = month_days(m_reg, leap);
    assign mon_done = (m_reg == 4'd12) || (rem_reg <= SW'(mlen));

    // serial days and validity of the day fields
    logic [SW-1:0] sa_next, sb_next, dist_next;
    logic          a_day_ok, b_day_ok;
    assign sa_next  = base_a_reg + SW'(month_start(ma_reg, leap_a_reg)) + SW'(da_reg);
    assign sb_next  = base_b_reg + SW'(month_start(mb_reg, leap_b_reg)) + SW'(db_reg);
    assign a_day_ok = (da_reg != 5'd0) && (da_reg <= month_days(ma_reg, leap_a_reg));
    assign b_day_ok = (db_reg != 5'd0) && (db_reg <= month_days(mb_reg, leap_b_reg));

    // distance and shifted serial
    logic signed [SSW-1:0] s_sum;
    logic                  oor_next;
    assign dist_next = (sa_reg >= sb_reg) ? (sa_reg - sb_reg) : (sb_reg - sa_reg);
    assign s_sum     = $signed({{(SSW - SW){1'b0}}, sa_reg})
                     + $signed({{(SSW - 19){off_reg[18]}}, off_reg});
    assign oor_next  = (s_sum < S_ONE) || (s_sum > S_LAST);

    // weekday of the result
    logic [5:0] wd_sum;
    assign wd_sum = 6'(wd_reg) + 6'(rem_reg[4:0]) - 6'd1;

    // item latch
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            da_reg  <= s_day_a;
            ma_reg  <= s_month_a;
            ya_reg  <= s_year_a;
            db_reg  <= s_day_b;
            mb_reg  <= s_month_b;
            yb_reg  <= s_year_b;
            off_reg <= s_day_offset;
        end
    end

    // status flags and capture marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_bad_reg <= 1'b0;
            b_bad_reg <= 1'b0;
            oor_reg   <= 1'b0;
            a_cap_reg <= 1'b0;
            b_cap_reg <= 1'b0;
        end else begin
            if (cmd.check) begin
                a_bad_reg <= !a_rng_ok;
                b_bad_reg <= !b_rng_ok;
                oor_reg   <= 1'b0;
                a_cap_reg <= 1'b0;
                b_cap_reg <= 1'b0;
            end
            if (cmd.walk1 && y_eq_a) begin
                a_cap_reg <= 1'b1;
            end
            if (cmd.walk1 && y_eq_b) begin
                b_cap_reg <= 1'b1;
            end
            if (cmd.eval1) begin
                a_bad_reg <= a_bad_reg || !a_day_ok;
                b_bad_reg <= b_bad_reg || !b_day_ok;
            end
            if (cmd.eval2) begin
                oor_reg <= oor_next;
            end
        end
    end

    // year walker shared by both walks
    always_ff @(posedge aclk) begin
        if (cmd.y_init) begin
            y_reg    <= YW'(FIRST_YEAR);
            m4_reg   <= 2'(FIRST_YEAR % 4);
            m100_reg <= 7'(FIRST_YEAR % 100);
            m400_reg <= 9'(FIRST_YEAR % 400);
            acc_reg  <= '0;
            wd_reg   <= 3'(JAN1_WD);
        end else begin
            if (adv) begin
                y_reg    <= y_reg + YW'(1);
                m4_reg   <= m4_reg + 2'd1;
                m100_reg <= (m100_reg == 7'd99) ? 7'd0 : m100_reg + 7'd1;
                m400_reg <= (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
            end
            if (cmd.walk1 && !walk1_done) begin
                acc_reg <= acc_reg + SW'(ylen);
            end
            if (cmd.walk2 && !walk2_done) begin
                wd_reg <= add_mod7(wd_reg, leap ? 3'd2 : 3'd1);
            end
            if (cmd.mon_step && !mon_done) begin
                wd_reg <= add_mod7(wd_reg, 3'(mlen - 5'd28));
            end
        end
    end

    // capture of year bases, serials, remainder and month
    always_ff @(posedge aclk) begin
        if (cmd.walk1 && y_eq_a) begin
            base_a_reg <= acc_reg;
            leap_a_reg <= leap;
        end
        if (cmd.walk1 && y_eq_b) begin
            base_b_reg <= acc_reg;
            leap_b_reg <= leap;
        end
        if (cmd.eval1) begin
            sa_reg <= sa_next;
            sb_reg <= sb_next;
        end
        if (cmd.eval2) begin
            dist_reg <= dist_next;
            rem_reg  <= s_sum[SW-1:0];
        end
        if (cmd.walk2 && !walk2_done) begin
            rem_reg <= rem_reg - SW'(ylen);
        end
        if (cmd.mon_init) begin
            m_reg <= 4'd1;
        end
        if (cmd.mon_step && !mon_done) begin
            rem_reg <= rem_reg - SW'(mlen);
            m_reg   <= m_reg + 4'd1;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            priority if (a_bad_reg) begin
                status_reg    <= ST_A_BAD;
                dist_out_reg  <= '0;
                sum_day_reg   <= '0;
                sum_month_reg <= '0;
                sum_year_reg  <= '0;
                sum_wd_reg    <= '0;
            end else if (b_bad_reg) begin
                status_reg    <= ST_B_BAD;
                dist_out_reg  <= '0;
                sum_day_reg   <= '0;
                sum_month_reg <= '0;
                sum_year_reg  <= '0;
                sum_wd_reg    <= '0;
            end else if (oor_reg) begin
                status_reg    <= ST_RANGE;
                dist_out_reg  <= 18'(dist_reg);
                sum_day_reg   <= '0;
                sum_month_reg <= '0;
                sum_year_reg  <= '0;
                sum_wd_reg    <= '0;
            end else begin
                status_reg    <= ST_OK;
                dist_out_reg  <= 18'(dist_reg);
                sum_day_reg   <= rem_reg[4:0];
                sum_month_reg <= m_reg;
                sum_year_reg  <= 12'(y_reg);
                sum_wd_reg    <= mod7_6(wd_sum);
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sum_day      = sum_day_reg;
    assign m_sum_month    = sum_month_reg;
    assign m_sum_year     = sum_year_reg;
    assign m_sum_weekday  = sum_wd_reg;
    assign m_day_distance = dist_out_reg;
    assign m_status       = status_reg;

    // status back to the controller
    always_comb begin
        sts            = '0;
        sts.a_rng_bad  = !a_rng_ok;
        sts.walk1_done = walk1_done;
        sts.date_bad   = a_bad_reg || b_bad_reg;
        sts.oor        = oor_reg;
        sts.walk2_done = walk2_done;
        sts.mon_done   = mon_done;
        sts.out_free   = !m_valid_reg || m_ready;
    end

    `CDOD_ASSERT_IMP(a_ok_date_fields, aclk, aresetn, m_valid && (m_status == ST_OK), (m_sum_month >= 4'd1) && (m_sum_month <= 4'd12) && (m_sum_day != 5'd0))
    `CDOD_ASSERT_IMP(a_bad_date_zero, aclk, aresetn, m_valid && ((m_status == ST_A_BAD) || (m_status == ST_B_BAD)), (m_day_distance == 18'd0) && (m_sum_year == 12'd0))
    `CDOD_ASSERT_NEXT(a_walk2_shrinks, aclk, aresetn, cmd.walk2 && !walk2_done, rem_reg < $past(rem_reg))

endmodule

FILE: hw/rtl/calendar_date_offset_and_distance_top.sv
// top level of the gregorian date offset and day distance unit
//
//  channel | ports   | handshake         | payload
//  input   | s_*     | s_valid / s_ready | two dates and a signed day offset
//  result  | m_*     | m_valid / m_ready | shifted date, weekday, distance, status
//
// one item at a time; the year walker sets how long an item takes: it steps one year per
// cycle up to the later input year (year A only when date B is out of range), then again
// from the first year up to the result year, then takes up to eleven month steps.
// an item with date A out of range goes from the check straight to the result.
// reset clears the controller and the output valid; no clearing pass.
// a stalled result waits in the output register while the next item is taken and worked.
`timescale 1ns / 1ps

module calendar_date_offset_and_distance_top import cdod_pkg::*; #(
    parameter int FIRST_YEAR = 1900,
    parameter int YEAR_SPAN  = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [4:0]         s_day_a,
    input  logic [3:0]         s_month_a,
    input  logic [11:0]        s_year_a,
    input  logic [4:0]         s_day_b,
    input  logic [3:0]         s_month_b,
    input  logic [11:0]        s_year_b,
    input  logic signed [18:0] s_day_offset,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_sum_day,
    output logic [3:0]         m_sum_month,
    output logic [11:0]        m_sum_year,
    output logic [2:0]         m_sum_weekday,
    output logic [17:0]        m_day_distance,
    output logic [1:0]         m_status
);

    cdod_cmd_t cmd;
    cdod_sts_t sts;

    // sequencer
    cdod_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // arithmetic and result register
    cdod_dp #(
        .FIRST_YEAR (FIRST_YEAR),
        .YEAR_SPAN  (YEAR_SPAN)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_day_a        (s_day_a),
        .s_month_a      (s_month_a),
        .s_year_a       (s_year_a),
        .s_day_b        (s_day_b),
        .s_month_b      (s_month_b),
        .s_year_b       (s_year_b),
        .s_day_offset   (s_day_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sum_day      (m_sum_day),
        .m_sum_month    (m_sum_month),
        .m_sum_year     (m_sum_year),
        .m_sum_weekday  (m_sum_weekday),
        .m_day_distance (m_day_distance),
        .m_status       (m_status),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
